[design/edd_pkg.sv]
// Shared types and helpers for the error-diffusion ditherer.
// Holds the per-channel control bundle and the quantize-and-rescale function.
// No dependencies.
package edd_pkg;

  // Stage strobes and per-pixel flags passed from the sequencer to each channel.
  typedef struct packed {
    logic clr;       // frame start: drop carried errors
    logic acc_en;    // capture the corrected value
    logic quant_en;  // capture quantized value and error
    logic wb_en;     // commit carried errors for this pixel
    logic last_col;
    logic last_row;
  } edd_ctrl_t;

  // Keep the top bd bits of v and rescale them to 0..255, truncated.
  // For depths that divide 8 this is bit replication. Otherwise
  // k*255/kmax = k*a + floor(k*r/kmax) with 255 = a*kmax + r, where the
  // small quotient comes from a few constant compares.
  function automatic logic [7:0] edd_quant(input logic [7:0] v, input logic [3:0] bd);
    logic [15:0] k;
    logic [15:0] p;
    logic [15:0] base;
    logic [15:0] quo;
    logic [15:0] sum;
    logic [7:0]  q;
    k    = 16'd0;
    p    = 16'd0;
    base = 16'd0;
    quo  = 16'd0;
    sum  = 16'd0;
    q    = v;
    case (bd)
      4'd1: q = {8{v[7]}};
      4'd2: q = {4{v[7:6]}};
      4'd4: q = {2{v[7:4]}};
      4'd3: begin
        k    = {13'd0, v[7:5]};
        base = k * 16'd36;
        p    = k * 16'd3;
        for (int j = 1; j <= 3; j++) begin
          if (p >= 16'(j * 7)) quo = quo + 16'd1;
        end
        sum  = base + quo;
        q    = sum[7:0];
      end
      4'd5: begin
        k    = {11'd0, v[7:3]};
        base = k << 3;
        p    = k * 16'd7;
        for (int j = 1; j <= 7; j++) begin
          if (p >= 16'(j * 31)) quo = quo + 16'd1;
        end
        sum  = base + quo;
        q    = sum[7:0];
      end
      4'd6: begin
        k    = {10'd0, v[7:2]};
        base = k << 2;
        p    = k * 16'd3;
        for (int j = 1; j <= 3; j++) begin
          if (p >= 16'(j * 63)) quo = quo + 16'd1;
        end
        sum  = base + quo;
        q    = sum[7:0];
      end
      4'd7: begin
        k    = {9'd0, v[7:1]};
        base = k << 1;
        if (k == 16'd127) quo = 16'd1;
        sum  = base + quo;
        q    = sum[7:0];
      end
      default: q = v;
    endcase
    return q;
  endfunction

endpackage

[design/edd_chan.sv]
// One color channel of the error-diffusion ditherer: correction, quantization
// and the carried error terms for the current and next row.
// Depends on edd_pkg.
module edd_chan #(
  parameter int ERROR_BITS = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  input  edd_pkg::edd_ctrl_t           ctrl,
  input  logic [3:0]                   bd,
  input  logic [7:0]                   pix,
  input  logic signed [ERROR_BITS-1:0] mem_err,
  output logic [7:0]                   q,
  output logic signed [ERROR_BITS-1:0] below_left,
  output logic signed [ERROR_BITS-1:0] below
);
  import edd_pkg::*;

  localparam int EB = ERROR_BITS;
  localparam logic signed [EB:0] HI = {2'b00, {(EB-1){1'b1}}};
  localparam logic signed [EB:0] LO = {2'b11, {(EB-1){1'b0}}};

  function automatic logic signed [EB-1:0] sat_err(input logic signed [EB:0] s);
    logic signed [EB-1:0] r;
    r = s[EB-1:0];
    if (s > HI) r = HI[EB-1:0];
    if (s < LO) r = LO[EB-1:0];
    return r;
  endfunction

  logic [7:0]           v;
  logic signed [8:0]    e;
  logic signed [EB-1:0] right_carry;
  logic signed [EB-1:0] p0;
  logic signed [EB-1:0] p1;

  logic signed [EB:0]   acc_sum;
  logic signed [EB-1:0] acc;
  logic signed [EB:0]   acc_bias;
  logic signed [EB:0]   share;
  logic signed [EB:0]   corr;
  logic signed [EB:0]   ee;
  logic signed [EB:0]   e3;
  logic signed [EB:0]   e5;
  logic signed [EB:0]   e7;
  logic signed [EB-1:0] down_sum;
  logic [7:0]           q_next;

  // Division by 16 truncates toward zero: the arithmetic shift rounds down, so negative sums get a bias of 15.
  always_comb begin
    acc_sum  = {right_carry[EB-1], right_carry} + {mem_err[EB-1], mem_err};
    acc      = sat_err(acc_sum);
    acc_bias = {acc[EB-1], acc} + (acc[EB-1] ? (EB+1)'(15) : (EB+1)'(0));
    share    = acc_bias >>> 4;
    corr     = $signed({{(EB-7){1'b0}}, pix}) + share;
  end

  always_comb begin
    ee       = {{(EB-8){e[8]}}, e};
    e3       = (ee <<< 1) + ee;
    e5       = (ee <<< 2) + ee;
    e7       = (ee <<< 3) - ee;
    down_sum = sat_err({p1[EB-1], p1} + e5);
  end

  assign q_next     = edd_quant(v, bd);
  assign below_left = ctrl.last_row ? '0 : sat_err({p0[EB-1], p0} + e3);
  assign below      = ctrl.last_row ? '0 : down_sum;

  always_ff @(posedge clk) begin
    if (ctrl.acc_en) begin
      if (corr < 0) begin
        v <= 8'd0;
      end else if (corr > (EB+1)'(255)) begin
        v <= 8'd255;
      end else begin
        v <= corr[7:0];
      end
    end
    if (ctrl.quant_en) begin
      q <= q_next;
      e <= $signed({1'b0, v}) - $signed({1'b0, q_next});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_carry <= '0;
      p0          <= '0;
      p1          <= '0;
    end else if (ctrl.clr) begin
      right_carry <= '0;
      p0          <= '0;
      p1          <= '0;
    end else if (ctrl.wb_en) begin
      right_carry <= ctrl.last_col ? '0 : e7[EB-1:0];
      if (ctrl.last_row || ctrl.last_col) begin
        p0 <= '0;
        p1 <= '0;
      end else begin
        p0 <= down_sum;
        p1 <= ee[EB-1:0];
      end
    end
  end

endmodule

[design/error_diffusion_ditherer.sv]
// Top level of the error-diffusion ditherer: stream ports, configuration
// registers, frame position, next-row error memory and the pixel sequencer.
// Depends on edd_pkg and edd_chan.

// Floyd-Steinberg ditherer for RGB pixels in raster order: every input
// transaction yields exactly one output transaction carrying the quantized,
// rescaled pixel, with tlast marking the last pixel of the frame. Pixels are
// handled one at a time, in the order set by the next-row error memory,
// which is never read and written at once: the input transaction reads the
// entry for the column, correction (S_ACC) and quantization (S_QUANT)
// follow, and then write-back (S_WB), which also loads the output register,
// with a second write-back state (S_WB2) after it on the last pixel of a row
// whose last column is not column 0. A new input transaction is taken as
// soon as the previous pixel's write-back is done, even while its result
// still waits in the output register; a stalled output holds the sequencer
// only at write-back. The error memory is not swept at frame start. Instead,
// a fill mark counts how many leading columns were written in the current
// frame, and columns at or past it read as zero, so there is no clearing
// pass and no startup delay after reset. Configuration registers may be
// written when the block is idle and take effect on the next pixel: width 0
// acts as 1, widths above MAX_WIDTH act as MAX_WIDTH, height 0 acts as 1,
// and bit depth is held to 1..8.
module error_diffusion_ditherer #(
  parameter int MAX_WIDTH  = 1024,
  parameter int ERROR_BITS = 13
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Pixel input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  // Pixel output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic        m_axis_tlast    // end_of_frame
);
  import edd_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;
  localparam int EB = ERROR_BITS;
  localparam int MW = 3 * EB;
  localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DEPTH  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ACC   = 5'b00010,
    S_QUANT = 5'b00100,
    S_WB    = 5'b01000,
    S_WB2   = 5'b10000
  } seq_state_t;

  seq_state_t state;
  seq_state_t state_next;

  logic [10:0] image_width;
  logic [15:0] image_height;
  logic [3:0]  bit_depth;

  logic [AW-1:0] column_count;
  logic [15:0]   row_count;
  logic [AW:0]   fill;

  logic [CW-1:0] iw;
  logic [CW-1:0] w_last;
  logic [15:0]   h_last;
  logic [3:0]    bd_eff;
  logic          last_col_c;
  logic          last_row_c;
  logic          frame_start;
  logic [AW-1:0] x_c;
  logic          accept;
  logic          out_free;

  logic [23:0]   pix;
  logic [AW-1:0] x;
  logic          last_col;
  logic          last_row;
  logic          rd_valid;

  logic [MW-1:0] err_mem [MAX_WIDTH];
  logic [MW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_data;
  logic [MW-1:0] below_word;
  logic [MW-1:0] below_left_word;
  logic [MW-1:0] wr2_data;

  edd_ctrl_t  ctrl;
  logic [7:0] q_ch [3];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1024;
      image_height <= 16'd768;
      bit_depth    <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[10:0];
        REG_HEIGHT: image_height <= cfg_data;
        REG_DEPTH:  bit_depth    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Effective frame geometry and position of the incoming pixel.
  always_comb begin
    iw = CW'(image_width);
    if (iw == '0) begin
      w_last = '0;
    end else if (iw > MAXW) begin
      w_last = MAXW - CW'(1);
    end else begin
      w_last = iw - CW'(1);
    end
    h_last = (image_height == 16'd0) ? 16'd0 : image_height - 16'd1;
    if (bit_depth == 4'd0) begin
      bd_eff = 4'd1;
    end else if (bit_depth > 4'd8) begin
      bd_eff = 4'd8;
    end else begin
      bd_eff = bit_depth;
    end
    last_col_c  = CW'(column_count) >= w_last;
    last_row_c  = row_count >= h_last;
    frame_start = (column_count == '0) && (row_count == 16'd0);
    x_c         = last_col_c ? w_last[AW-1:0] : column_count;
  end

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_ACC;
      S_ACC:   state_next = S_QUANT;
      S_QUANT: state_next = S_WB;
      S_WB: begin
        if (out_free) begin
          state_next = (last_col && (x != '0)) ? S_WB2 : S_IDLE;
        end
      end
      S_WB2:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Frame position. Changing the geometry mid-frame takes effect at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= 16'd0;
    end else if (accept) begin
      if (last_col_c) begin
        column_count <= '0;
        row_count    <= last_row_c ? 16'd0 : row_count + 16'd1;
      end else begin
        column_count <= column_count + AW'(1);
      end
    end
  end

  // Per-pixel captures for the sequence that follows the input transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      pix      <= s_axis_tdata;
      x        <= x_c;
      last_col <= last_col_c;
      last_row <= last_row_c;
      rd_valid <= !frame_start && ({1'b0, x_c} < fill);
    end
  end

  // Every row writes a prefix of columns, so the set of entries written in
  // this frame is always [0, fill). Entries beyond it still hold last frame's
  // data and read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept && frame_start) begin
      fill <= '0;
    end else if (wr_en && (({1'b0, wr_addr} + (AW+1)'(1)) > fill)) begin
      fill <= {1'b0, wr_addr} + (AW+1)'(1);
    end
  end

  // Write-back: the below-left share goes to column x-1; on the last pixel
  // of a row the below share for column x follows in the second write-back state. At column 0
  // only the latter exists, and it goes out in the first write-back state.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = x;
    wr_data = wr2_data;
    if ((state == S_WB) && out_free) begin
      wr_en   = (x != '0) || last_col;
      wr_addr = (x == '0) ? x : x - AW'(1);
      wr_data = (x == '0) ? below_word : below_left_word;
    end else if (state == S_WB2) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_WB) && out_free) begin
      wr2_data <= below_word;
    end
  end

  // Next-row error memory: one write and one registered read per cycle.
  // Reads and writes never fall in the same cycle, as the sequencer reads
  // only on an input transaction, after the previous write-back.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      err_mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_data <= err_mem[x_c];
    end
  end

  always_comb begin
    ctrl          = '0;
    ctrl.clr      = accept && frame_start;
    ctrl.acc_en   = (state == S_ACC);
    ctrl.quant_en = (state == S_QUANT);
    ctrl.wb_en    = (state == S_WB) && out_free;
    ctrl.last_col = last_col;
    ctrl.last_row = last_row;
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic signed [EB-1:0] mem_err;
    logic signed [EB-1:0] bl;
    logic signed [EB-1:0] bd_err;

    assign mem_err = rd_valid ? rd_data[c*EB +: EB] : '0;

    edd_chan #(
      .ERROR_BITS (EB)
    ) u_chan (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .bd         (bd_eff),
      .pix        (pix[c*8 +: 8]),
      .mem_err    (mem_err),
      .q          (q_ch[c]),
      .below_left (bl),
      .below      (bd_err)
    );

    assign below_left_word[c*EB +: EB] = bl;
    assign below_word[c*EB +: EB]      = bd_err;
  end

  // Output register: the result waits here while the next pixel is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_WB) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_WB) && out_free) begin
      m_axis_tdata <= {q_ch[2], q_ch[1], q_ch[0]};
      m_axis_tlast <= last_col && last_row;
    end
  end

endmodule

[tb/edd_tb_pkg.sv]
`timescale 1ns / 1ps
// Names shared by the ditherer testbench files: the configuration register map.
// No dependencies.
package edd_tb_pkg;

  // Register indexes of the configuration write port. The last index is not
  // mapped in the block, and a write to it must change nothing.
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BIT_DEPTH    = 2'd2,
    REG_UNUSED       = 2'd3
  } edd_reg_e;

endpackage

[tb/ditherer_checker.sv]
`timescale 1ns / 1ps
// Checker for the error-diffusion ditherer: follows the configuration port and
// both pixel streams, predicts every dithered pixel and compares the results.
// Depends on edd_tb_pkg.
module ditherer_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int ERROR_BITS = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_valid,
  input  logic        s_ready,
  input  logic [23:0] s_data,
  input  logic        m_valid,
  input  logic        m_ready,
  input  logic [23:0] m_data,
  input  logic        m_last,
  output int          fail_count,
  output int          pending_count
);
  import edd_tb_pkg::*;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ERR_HI   = (1 << (ERROR_BITS - 1)) - 1;
  localparam int ERR_LO   = -ERR_HI - 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       end_of_frame;
  } dithered_pixel_t;

  // Shadow of the configuration registers.
  logic [10:0] image_width;
  logic [15:0] image_height;
  logic [3:0]  bit_depth;

  // Diffusion state, errors in sixteenths, one entry per channel.
  int row_err [3][MAX_WIDTH];
  int carry_right [3];
  int below_left [3];   // owed to column x-1 of the next row
  int below_here [3];   // owed to column x of the next row
  logic [COL_BITS-1:0] col_pos;
  logic [15:0]         row_pos;

  dithered_pixel_t expected_pixels [$];
  int mismatches = 0;
  int waiting    = 0;
  int results    = 0;

  assign fail_count    = mismatches;
  assign pending_count = waiting;

  function automatic int clamp_err(input int v);
    if (v > ERR_HI) return ERR_HI;
    if (v < ERR_LO) return ERR_LO;
    return v;
  endfunction

  function automatic void clear_errors();
    foreach (row_err[c, i]) row_err[c][i] = 0;
    for (int c = 0; c < 3; c++) begin
      carry_right[c] = 0;
      below_left[c]  = 0;
      below_here[c]  = 0;
    end
  endfunction

  // Dithers one pixel and advances the frame position.
  function automatic dithered_pixel_t dither_pixel(input logic [23:0] px);
    int w, h, bd, mask, x, pix, acc, v, q, e;
    logic last_col, last_row;
    logic [7:0] chan [3];
    dithered_pixel_t res;
    w    = (image_width == 0) ? 1 : ((image_width > MAX_WIDTH) ? MAX_WIDTH : image_width);
    h    = (image_height == 0) ? 1 : image_height;
    bd   = (bit_depth == 0) ? 1 : ((bit_depth > 8) ? 8 : bit_depth);
    mask = (32'hFF << (8 - bd)) & 32'hFF;
    if (col_pos == 0 && row_pos == 0) clear_errors();
    x        = (int'(col_pos) >= w) ? w - 1 : int'(col_pos);
    last_col = int'(col_pos) >= w - 1;
    last_row = int'(row_pos) >= h - 1;
    for (int c = 0; c < 3; c++) begin
      pix = px[8*c +: 8];
      acc = clamp_err(carry_right[c] + row_err[c][x]);
      v   = pix + acc / 16;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      q   = ((v & mask) * 255) / mask;
      e   = v - q;
      chan[c] = q[7:0];
      carry_right[c] = last_col ? 0 : 7 * e;
      if (last_row) begin
        // Nothing is owed below the last row.
        row_err[c][x] = 0;
        if (x > 0) row_err[c][x-1] = 0;
        below_left[c] = 0;
        below_here[c] = 0;
      end else begin
        if (x > 0) row_err[c][x-1] = clamp_err(below_left[c] + 3 * e);
        below_left[c] = clamp_err(below_here[c] + 5 * e);
        below_here[c] = last_col ? 0 : e;
        if (last_col) begin
          row_err[c][x] = below_left[c];
          below_left[c] = 0;
        end
      end
    end
    res.red          = chan[0];
    res.green        = chan[1];
    res.blue         = chan[2];
    res.end_of_frame = last_col && last_row;
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? 16'd0 : row_pos + 16'd1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: result %0d: %s: got 0x%0h, expected 0x%0h",
             $time, results, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    dithered_pixel_t want;
    if (rst) begin
      image_width  = 11'd1024;
      image_height = 16'd768;
      bit_depth    = 4'd1;
      clear_errors();
      col_pos = '0;
      row_pos = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (edd_reg_e'(cfg_index))
          REG_IMAGE_WIDTH:  image_width  = cfg_data[10:0];
          REG_IMAGE_HEIGHT: image_height = cfg_data;
          REG_BIT_DEPTH:    bit_depth    = cfg_data[3:0];
          default: ;
        endcase
      end
      if (s_valid && s_ready) expected_pixels.push_back(dither_pixel(s_data));
      if (m_valid && m_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result with no pixel waiting", int'(m_data), 0);
        end else begin
          want = expected_pixels.pop_front();
          if (m_data[7:0] !== want.red)
            report_mismatch("red", int'(m_data[7:0]), int'(want.red));
          if (m_data[15:8] !== want.green)
            report_mismatch("green", int'(m_data[15:8]), int'(want.green));
          if (m_data[23:16] !== want.blue)
            report_mismatch("blue", int'(m_data[23:16]), int'(want.blue));
          if (m_last !== want.end_of_frame)
            report_mismatch("end of frame", int'(m_last), int'(want.end_of_frame));
        end
        results++;
      end
    end
    waiting <= expected_pixels.size();
  end

endmodule

[tb/error_diffusion_ditherer_tb.sv]
`timescale 1ns / 1ps
// Top of the ditherer testbench: clock, reset, configuration writes, pixel
// stimulus, output back-pressure and the verdict. Depends on edd_tb_pkg,
// ditherer_checker and the error_diffusion_ditherer RTL.
module error_diffusion_ditherer_tb;
  import edd_tb_pkg::*;

  // Pixels in the random part, not counting the one full-width phase.
  localparam int RANDOM_ITEMS   = 400;
  // Cycles to let pass once the last result is in; the block's write-back
  // may still run after its result is offered.
  localparam int SETTLE_CYCLES  = 12;
  // Long receiver stall used to fill the block and stall its input.
  localparam int HOLD_CYCLES    = 64;
  // Cycles without any transaction or write before the run is declared hung.
  // The longest legal quiet stretch is the long stall above.
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst           = 1'b1;
  logic        cfg_we        = 1'b0;
  logic [1:0]  cfg_index     = REG_IMAGE_WIDTH;
  logic [15:0] cfg_data      = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  int fail_count;
  int pending_count;

  // Idling controls shared by the sender and the receiver. idle_pct is the
  // chance, in percent, that a burst of idle cycles starts; calm turns all
  // idling off for the last part of the run.
  int idle_pct     = 10;
  bit calm         = 1'b0;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;

  logic [23:0] directed_pixels [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  error_diffusion_ditherer DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // red[7:0], green[15:8], blue[23:16]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // red[7:0], green[15:8], blue[23:16]
    .m_axis_tlast  (m_axis_tlast)    // end_of_frame
  );

  ditherer_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_valid       (s_axis_tvalid),
    .s_ready       (s_axis_tready),
    .s_data        (s_axis_tdata),
    .m_valid       (m_axis_tvalid),
    .m_ready       (m_axis_tready),
    .m_data        (m_axis_tdata),
    .m_last        (m_axis_tlast),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Offers one pixel, possibly after a short idle burst, and returns at the
  // clock edge where the transaction completes. tvalid stays high on return
  // so that back-to-back pixels see no gap unless the next call adds one.
  task automatic send_pixel(input logic [23:0] px);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stops offering pixels and waits until every result has come out and the
  // block has finished its write-back, so it is idle for register writes.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers and the unmapped index. The bits above the
  // width and depth fields carry random values, which the block must drop.
  task automatic configure(input logic [10:0] w, input logic [15:0] h, input logic [3:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= {5'($urandom), w};
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_BIT_DEPTH;
    cfg_data  <= {12'($urandom), d};
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Pixel content styles: plain noise, channel extremes, a flat area with
  // slight noise around a base color (where the diffused error matters most),
  // and grays.
  function automatic logic [23:0] make_pixel(input int style, input logic [23:0] base);
    logic [23:0] px;
    int ch;
    px = 24'($urandom);
    for (int c = 0; c < 3; c++) begin
      case (style)
        1: begin
          case ($urandom_range(0, 3))
            0: px[8*c +: 8] = 8'd0;
            1: px[8*c +: 8] = 8'd1;
            2: px[8*c +: 8] = 8'd254;
            default: px[8*c +: 8] = 8'd255;
          endcase
        end
        2: begin
          ch = int'(base[8*c +: 8]) + $urandom_range(0, 15) - 8;
          px[8*c +: 8] = (ch < 0) ? 8'd0 : ((ch > 255) ? 8'd255 : 8'(ch));
        end
        3: px[8*c +: 8] = px[7:0];
        default: ;
      endcase
    end
    return px;
  endfunction

  // Receiver: random stall bursts, plus one long hold whenever the stimulus
  // asks for it. The long hold is counted here, while the sender keeps
  // offering pixels, so the block fills and drops its input ready.
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: any transaction on either stream or a register write counts
  // as progress.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic [10:0] w;
    logic [15:0] h;
    logic [3:0]  d;
    logic [23:0] base;
    int eff_w, eff_h, count, style, phase, sent;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. First the reset settings: a 1024 x 768 frame at one bit
    // per channel, with black, white and the values on either side of the
    // one-bit threshold.
    directed_pixels = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h7F7F7F,
                        24'h00FF00, 24'hFF00FF};
    foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);
    settle();

    // Zero width, height and depth act as 1: every pixel is a whole frame,
    // so each result carries end of frame and no error survives.
    configure(11'd0, 16'd0, 4'd0);
    directed_pixels = '{24'h7F7F7F, 24'h808080, 24'h030201, 24'hFCFDFE};
    foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);
    settle();

    // Width above the maximum is held to the maximum, depth above 8 to 8,
    // where quantization is lossless.
    configure(11'd2047, 16'd2, 4'd15);
    directed_pixels = '{24'hC35AA5, 24'h000000, 24'hFFFFFF};
    foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);
    settle();

    // A full 3 x 3 frame at three bits, a depth that does not divide 8:
    // corners, edges and the center all see different sets of shares.
    configure(11'd3, 16'd3, 4'd3);
    directed_pixels = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h7F7F7F,
                        24'h808080, 24'hFFFFFF, 24'h000000, 24'h3C9E11};
    foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);
    settle();

    // Random part. Each phase writes new settings while the block is idle;
    // frame position is kept across phases, so a phase that stops mid-frame
    // exercises registers changed in the middle of a frame.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 1) begin
        // The one full-width phase: past the last column of the first row,
        // with the next row's errors written at every column.
        w     = ($urandom_range(0, 1) != 0) ? 11'd1024 : 11'($urandom_range(1025, 2047));
        h     = 16'd2;
        d     = 4'($urandom_range(1, 8));
        count = 1100;
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    w = 11'($urandom);
          2:       w = 11'($urandom_range(17, 80));
          3:       w = 11'd1;
          default: w = 11'($urandom_range(2, 16));
        endcase
        case ($urandom_range(0, 9))
          0:       h = 16'd0;
          1:       h = 16'($urandom);
          2:       h = 16'd1;
          default: h = 16'($urandom_range(2, 6));
        endcase
        d     = 4'($urandom);
        eff_w = (w == 0) ? 1 : ((w > 1024) ? 1024 : w);
        eff_h = (h == 0) ? 1 : h;
        if (eff_w * eff_h <= 48)
          count = eff_w * eff_h * $urandom_range(1, 3);
        else
          count = $urandom_range(10, 120);
      end
      // The first phase with the long receiver hold offers enough pixels to fill
      // the block while the hold lasts.
      if (phase == 3 && count < 16) count = 16;
      configure(w, h, d);

      calm = (sent >= RANDOM_ITEMS - RANDOM_ITEMS / 10);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (phase == 3 || phase == 9) hold_request = 1'b1;

      style = $urandom_range(0, 3);
      base  = 24'($urandom);
      repeat (count) send_pixel(make_pixel(style, base));
      if (phase != 1) sent += count;
      phase++;

      // The sender pauses here until every expected result has arrived.
      settle();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[error_diffusion_ditherer.f]
design/edd_pkg.sv
design/edd_chan.sv
design/error_diffusion_ditherer.sv
tb/edd_tb_pkg.sv
tb/ditherer_checker.sv
tb/error_diffusion_ditherer_tb.sv
